// ----- rtl/remote_address_slot_table_top_assert.svh -----
// assertion shorthands used by the checker file
`ifndef REMOTE_ADDRESS_SLOT_TABLE_TOP_ASSERT_SVH
`define REMOTE_ADDRESS_SLOT_TABLE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RAST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define RAST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rast_pkg.sv -----
package rast_pkg;

  localparam int unsigned SlotW  = 3;
  localparam int unsigned PathW  = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NOMATCH = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_MARK,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [7:0]  addr_id;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot;
    logic             list_changed;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [7:0]  addr_id;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

// ----- rtl/rast_front.sv -----
module rast_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rast_pkg::req_t     in_item_i,
  output logic               push_o,
  output rast_pkg::cmd_t     cmd_o,
  input  rast_pkg::q_flags_t q_flags_i
);
  import rast_pkg::*;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_MARK   = 2'd2;

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic accept;
  op_e  op;

  // request decode
  always_comb begin
    unique case (in_item_i.func)
      FUNC_ADD:    op = OP_ADD;
      FUNC_REMOVE: op = OP_REMOVE;
      FUNC_MARK:   op = OP_MARK;
      default:     op = OP_NONE;
    endcase
  end

  assign push_o     = valid_q && !q_flags_i.full;
  assign in_stall_o = valid_q && q_flags_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !push_o);
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op        <= op;
      cmd_q.peer_addr <= in_item_i.peer_addr;
      cmd_q.peer_port <= in_item_i.peer_port;
      cmd_q.addr_id   <= in_item_i.addr_id;
    end
  end

endmodule

// ----- rtl/rast_fifo.sv -----
module rast_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rast_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output rast_pkg::cmd_t     cmd_o,
  output rast_pkg::q_flags_t flags_o
);
  import rast_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign flags_o.full  = (cnt_q == FullCnt);
  assign flags_o.empty = (cnt_q == '0);
  assign cmd_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/rast_back.sv -----
module rast_back #(
  parameter int unsigned SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rast_pkg::q_flags_t q_flags_i,
  input  rast_pkg::cmd_t     cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rast_pkg::rsp_t     out_item_o
);
  import rast_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // slot table
  logic [SLOTS-1:0] valid_q;
  logic [31:0]      addr_q [SLOTS];
  logic [15:0]      port_q [SLOTS];
  logic [7:0]       id_q   [SLOTS];
  logic [PathW-1:0] path_q [SLOTS];

  logic            state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_item_q, out_item_d;

  logic            out_free;
  logic            cur_valid, id_hit, addr_eq, port_eq;
  logic            finish;
  rsp_t            rsp;
  logic            wr_upd, wr_claim, wr_clr, wr_mark;
  logic [IdxW-1:0] claim_idx;

  function automatic rsp_t mk_rsp(logic [1:0] status, logic [IdxW-1:0] idx, logic changed);
    rsp_t r;
    r.status       = status;
    r.slot         = SlotW'(idx);
    r.list_changed = changed;
    return r;
  endfunction

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == S_IDLE) && !q_flags_i.empty && out_free;
  assign cur_valid = valid_q[idx_q];
  assign id_hit    = cur_valid && (id_q[idx_q] == cmd_q.addr_id);
  assign addr_eq   = (addr_q[idx_q] == cmd_q.peer_addr);
  assign port_eq   = (port_q[idx_q] == cmd_q.peer_port);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_item_d   = out_item_q;
    finish       = 1'b0;
    rsp          = mk_rsp(STATUS_NOMATCH, '0, 1'b0);
    wr_upd       = 1'b0;
    wr_claim     = 1'b0;
    wr_clr       = 1'b0;
    wr_mark      = 1'b0;
    claim_idx    = free_found_q ? free_idx_q : idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          if (cmd_i.op == OP_NONE) begin
            out_valid_d = 1'b1;
            out_item_d  = mk_rsp(STATUS_NOMATCH, '0, 1'b0);
          end else begin
            cmd_d        = cmd_i;
            idx_d        = '0;
            free_found_d = 1'b0;
            state_d      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        unique case (cmd_q.op)
          OP_ADD: begin
            if (id_hit && addr_eq && port_eq) begin
              finish = 1'b1;
              rsp    = mk_rsp(STATUS_DONE, idx_q, 1'b0);
            end else if (id_hit && !addr_eq) begin
              finish = 1'b1;
              wr_upd = 1'b1;
              rsp    = mk_rsp(STATUS_DONE, idx_q, 1'b1);
            end
          end
          OP_REMOVE: begin
            if (id_hit) begin
              finish = 1'b1;
              wr_clr = 1'b1;
              rsp    = mk_rsp(STATUS_DONE, idx_q, 1'b0);
            end
          end
          OP_MARK: begin
            if (cur_valid && addr_eq) begin
              finish  = 1'b1;
              wr_mark = 1'b1;
              rsp     = mk_rsp(STATUS_DONE, idx_q, 1'b0);
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase

        // remember the lowest free slot for a later claim
        if (!cur_valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end

        if (!finish && (idx_q == LastIdx)) begin
          finish = 1'b1;
          if (cmd_q.op == OP_ADD) begin
            if (free_found_q || !cur_valid) begin
              wr_claim = 1'b1;
              rsp      = mk_rsp(STATUS_DONE, claim_idx, 1'b1);
            end else begin
              rsp = mk_rsp(STATUS_FULL, '0, 1'b0);
            end
          end
        end

        if (finish) begin
          out_valid_d = 1'b1;
          out_item_d  = rsp;
          state_d     = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (wr_claim) begin
        valid_q[claim_idx] <= 1'b1;
      end
      if (wr_clr) begin
        valid_q[idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    out_item_q   <= out_item_d;
    if (wr_upd) begin
      addr_q[idx_q] <= cmd_q.peer_addr;
      port_q[idx_q] <= cmd_q.peer_port;
    end
    if (wr_claim) begin
      addr_q[claim_idx] <= cmd_q.peer_addr;
      port_q[claim_idx] <= cmd_q.peer_port;
      id_q[claim_idx]   <= cmd_q.addr_id;
      path_q[claim_idx] <= '0;
    end
    if (wr_mark) begin
      path_q[idx_q] <= path_q[idx_q] | PathW'(1);
    end
  end

endmodule

// ----- rtl/remote_address_slot_table_top.sv -----
// remote address slot table: keeps up to SLOTS peer ipv4 addresses, each with
// an address id, a port and per-path bits. an item is one request (add, remove
// by id, mark initial flow) and gives exactly one result item. the front stage
// registers and decodes each item into a two-entry queue, so the input keeps
// flowing while the table is busy or a result waits, until the queue is full;
// the back stage walks the table one slot per cycle through a single compare
// unit. an add, remove or mark leaves the queue and then visits slots in order
// until it finishes or reaches the last slot; an unused request code is
// answered straight from the queue. the slot scan sets the sustained rate: the
// back stage takes no new item from the queue until the current scan is done.
// the front register lies between input accept and the queue.
// the table starts empty after reset; no clearing pass is needed since only
// valid slots are ever read. retry bits are always zero in this request set
// and are not stored
module remote_address_slot_table_top #(
  parameter int unsigned SLOTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rast_pkg::req_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rast_pkg::rsp_t out_item_o
);
  import rast_pkg::*;

  // front to queue
  logic     push;
  cmd_t     push_cmd;
  // queue to back
  logic     pop;
  cmd_t     head_cmd;
  q_flags_t q_flags;

  // decode and hold one item until the queue has room
  rast_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .q_flags_i  (q_flags)
  );

  // short command queue decoupling the two sides
  rast_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .flags_o (q_flags)
  );

  // slot table, scan sequencer and result register
  rast_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_flags_i   (q_flags),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/rast_checker.sv -----
`include "remote_address_slot_table_top_assert.svh"

module rast_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_stall_i,
  input rast_pkg::rsp_t out_item_i
);
  import rast_pkg::*;

  `RAST_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_item_i), "stalled result dropped or changed")
  `RAST_ASSERT_IMP(a_status_code, out_valid_i, out_item_i.status == STATUS_DONE || out_item_i.status == STATUS_FULL || out_item_i.status == STATUS_NOMATCH, "unused status code")
  `RAST_ASSERT_IMP(a_full_fields, out_valid_i && out_item_i.status == STATUS_FULL, out_item_i.slot == '0 && !out_item_i.list_changed, "table full result with slot or change set")
  `RAST_ASSERT_IMP(a_nomatch_fields, out_valid_i && out_item_i.status == STATUS_NOMATCH, out_item_i.slot == '0 && !out_item_i.list_changed, "no match result with slot or change set")

endmodule

bind remote_address_slot_table_top rast_checker u_rast_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);

// ----- tb/sv/tb_remote_address_slot_table_top.sv -----
`timescale 1ns / 1ps

module tb_remote_address_slot_table_top;
  import rast_pkg::*;

  // table size of the block under test; the slot field carries the low bits
  localparam int unsigned SLOTS = 8;

  // drain at the end, sized from SLOTS so that it outlasts an item's trip
  // through the front register, the queue and a full scan
  localparam int unsigned DRAIN_CYCLES = 4 * (SLOTS + 3);

  // cycles with no item moved on either side before the run is declared hung;
  // the slowest legal gap is one scan plus long random stalls on both sides
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // random items per idle pattern
  localparam int unsigned ITEMS_PER_PHASE = 210;

  // ------------------------------------------------------------------------
  // scoreboard: mirrors the slot table and keeps the results still owed
  // ------------------------------------------------------------------------
  class peer_table_tracker;
    logic        live     [SLOTS];
    logic [31:0] addr_of  [SLOTS];
    logic [15:0] port_of  [SLOTS];
    logic [7:0]  id_of    [SLOTS];
    logic [7:0]  path_of  [SLOTS];
    rsp_t        awaited_rsp[$];
    int          errors;
    int          checked;
    int          op_count [4];
    int          full_count;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      errors     = 0;
      checked    = 0;
      full_count = 0;
      foreach (op_count[k]) op_count[k] = 0;
    endfunction

    // one request against the mirrored table, updating it as the block would
    function rsp_t apply_request(req_t req);
      rsp_t r;
      int   hit;
      r.status       = STATUS_NOMATCH;
      r.slot         = '0;
      r.list_changed = 1'b0;
      hit            = -1;
      case (op_e'(req.func))
        OP_ADD: begin
          // same id: exact match is a no-op, other address is rewritten;
          // same id and address with another port lets the scan go on
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && live[i] && id_of[i] == req.addr_id) begin
              if (addr_of[i] == req.peer_addr && port_of[i] == req.peer_port) begin
                hit      = i;
                r.status = STATUS_DONE;
                r.slot   = SlotW'(i);
              end else if (addr_of[i] != req.peer_addr) begin
                hit            = i;
                addr_of[i]     = req.peer_addr;
                port_of[i]     = req.peer_port;
                r.status       = STATUS_DONE;
                r.slot         = SlotW'(i);
                r.list_changed = 1'b1;
              end
            end
          end
          // no finishing id hit: claim the lowest free slot
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && !live[i]) begin
              hit            = i;
              live[i]        = 1'b1;
              addr_of[i]     = req.peer_addr;
              port_of[i]     = req.peer_port;
              id_of[i]       = req.addr_id;
              path_of[i]     = '0;
              r.status       = STATUS_DONE;
              r.slot         = SlotW'(i);
              r.list_changed = 1'b1;
            end
          end
          if (hit < 0) r.status = STATUS_FULL;
        end
        OP_REMOVE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && live[i] && id_of[i] == req.addr_id) begin
              hit      = i;
              live[i]  = 1'b0;
              r.status = STATUS_DONE;
              r.slot   = SlotW'(i);
            end
          end
        end
        OP_MARK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && live[i] && addr_of[i] == req.peer_addr) begin
              hit        = i;
              path_of[i] = path_of[i] | 8'h01;
              r.status   = STATUS_DONE;
              r.slot     = SlotW'(i);
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(req_t req);
      rsp_t want;
      want = apply_request(req);
      op_count[req.func]++;
      if (want.status == STATUS_FULL) full_count++;
      awaited_rsp.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        $display("%0t: result item with none outstanding: status=%0d slot=%0d changed=%0d",
                 $time, got.status, got.slot, got.list_changed);
        errors++;
        return;
      end
      want = awaited_rsp.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: slot mismatch: expected %0d, actual %0d",
                 $time, want.slot, got.slot);
        errors++;
      end
      if (got.list_changed !== want.list_changed) begin
        $display("%0t: list_changed mismatch: expected %0d, actual %0d",
                 $time, want.list_changed, got.list_changed);
        errors++;
      end
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // clock, reset and the block
  // ------------------------------------------------------------------------
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_item_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_item_o;

  // idle percentages of the current phase, read at falling edges
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // request pools so that random adds, removes and marks hit live slots
  logic [7:0]  id_pool   [10];
  logic [31:0] addr_pool [6];
  logic [15:0] port_pool [3];

  peer_table_tracker tracker = new();
  int unsigned       quiet_cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  remote_address_slot_table_top #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // ------------------------------------------------------------------------
  // monitors: both handshakes sampled at the rising edge
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // a result can never belong to an item accepted on the same edge
      if (out_valid_o && !out_stall_i) tracker.check_response(out_item_o);
      if (in_valid_i && !in_stall_o) tracker.note_request(in_item_i);
    end
  end

  // receiver stalls at random, independent of valid
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // hang detector: counts edges where neither side moves an item
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic req_t make_req(op_e op, logic [31:0] addr, logic [15:0] port,
                                    logic [7:0] id);
    req_t r;
    r.func      = op;
    r.peer_addr = addr;
    r.peer_port = port;
    r.addr_id   = id;
    return r;
  endfunction

  // drives one item at the falling edge, with optional idle cycles ahead of it,
  // and returns at the rising edge that accepts it; valid stays high after
  task automatic send_request(input req_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender holds off until every owed result is back
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.awaited_rsp.size() != 0) @(posedge clk_i);
  endtask

  // fresh pools with the field extremes always present
  task automatic refresh_pools();
    foreach (id_pool[k]) id_pool[k] = 8'($urandom());
    foreach (addr_pool[k]) addr_pool[k] = $urandom();
    foreach (port_pool[k]) port_pool[k] = 16'($urandom());
    id_pool[0]   = 8'h00;
    id_pool[1]   = 8'hff;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hffff_ffff;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hffff;
  endtask

  // mostly pooled requests that hit the table, some fully random noise
  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 12) begin
      r.func      = 2'($urandom_range(3));
      r.peer_addr = $urandom();
      r.peer_port = 16'($urandom());
      r.addr_id   = 8'($urandom());
    end else begin
      if (roll < 50)      r.func = OP_ADD;
      else if (roll < 72) r.func = OP_REMOVE;
      else if (roll < 95) r.func = OP_MARK;
      else                r.func = OP_NONE;
      r.peer_addr = addr_pool[$urandom_range(5)];
      r.peer_port = port_pool[$urandom_range(2)];
      r.addr_id   = id_pool[$urandom_range(9)];
    end
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    // reset held low from the start, released at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, no idling
    send_request(make_req(OP_REMOVE, 32'h0, 16'h0, 8'h00));         // remove on empty table
    send_request(make_req(OP_MARK, 32'h0, 16'h0, 8'h00));           // mark on empty table
    send_request(make_req(OP_NONE, 32'hffff_ffff, 16'hffff, 8'hff)); // unused code
    send_request(make_req(OP_ADD, 32'h0, 16'h0, 8'h00));            // first claim, slot 0
    send_request(make_req(OP_ADD, 32'h0, 16'h0, 8'h00));            // exact match
    send_request(make_req(OP_ADD, 32'h0, 16'hffff, 8'h00));         // same id and addr, new port
    send_request(make_req(OP_ADD, 32'h0, 16'hffff, 8'h00));         // exact match past slot 0
    send_request(make_req(OP_ADD, 32'hffff_ffff, 16'h0005, 8'h00)); // id match, addr rewrite
    send_request(make_req(OP_ADD, 32'h0a00_0001, 16'h1f90, 8'hff)); // fill the rest
    send_request(make_req(OP_ADD, 32'h0a00_0002, 16'h0000, 8'h01));
    send_request(make_req(OP_ADD, 32'h8000_0000, 16'h8000, 8'h02));
    send_request(make_req(OP_ADD, 32'h7fff_ffff, 16'h7fff, 8'h03));
    send_request(make_req(OP_ADD, 32'hc0a8_0101, 16'h0050, 8'h04));
    send_request(make_req(OP_ADD, 32'h5555_aaaa, 16'haaaa, 8'h05));
    send_request(make_req(OP_ADD, 32'h1234_5678, 16'h0001, 8'h09)); // table full
    send_request(make_req(OP_MARK, 32'hffff_ffff, 16'h0, 8'h00));   // mark hit on slot 0
    send_request(make_req(OP_MARK, 32'hdead_beef, 16'h0, 8'h00));   // mark miss
    send_request(make_req(OP_REMOVE, 32'h0, 16'h0, 8'h00));         // frees slot 0
    send_request(make_req(OP_REMOVE, 32'h0, 16'h0, 8'h00));         // frees slot 1
    send_request(make_req(OP_REMOVE, 32'h0, 16'h0, 8'hff));         // frees slot 2
    send_request(make_req(OP_ADD, 32'h0b00_0007, 16'h0000, 8'h07)); // lowest free slot again
    send_request(make_req(OP_REMOVE, 32'h0, 16'h0, 8'hc8));         // remove miss
    send_request(make_req(OP_NONE, 32'h0, 16'h0, 8'h00));           // unused code, zero fields
    wait_for_results();

    // random part over four idle patterns, draining after each
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      refresh_pools();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(random_request());
      end
      wait_for_results();
    end

    // final drain: nothing owed, then let any late item show up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (tracker.awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d add, %0d remove, %0d mark and %0d unused-code requests",
             tracker.op_count[OP_ADD], tracker.op_count[OP_REMOVE],
             tracker.op_count[OP_MARK], tracker.op_count[OP_NONE]);
    $display("checked %0d results (%0d table full) under four idle patterns, %0d mismatches",
             tracker.checked, tracker.full_count, tracker.errors);
    if (tracker.errors == 0 && tracker.awaited_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- remote_address_slot_table_top.f -----
+incdir+rtl
rtl/rast_pkg.sv
rtl/rast_front.sv
rtl/rast_fifo.sv
rtl/rast_back.sv
rtl/remote_address_slot_table_top.sv
rtl/rast_checker.sv
tb/sv/tb_remote_address_slot_table_top.sv
